FILE: hdl/lcent_pkg.sv
package lcent_pkg;

    // Default depth of one scan; the sample index wraps after this many samples.
    localparam int MAX_SAMPLES_DEF = 4096;

    // Significant bits of a range sample and of an angle code.
    localparam int RANGE_BITS = 16;
    localparam int ANGLE_BITS = 16;

    // Mask applied to an incoming range sample.
    localparam logic [15:0] RANGE_MASK = (RANGE_BITS >= 16) ? 16'hFFFF
                                       : 16'((32'd1 << RANGE_BITS) - 32'd1);

    // Width of the running coordinate sums, which saturate at this width.
    localparam int SUM_W = 30;

    // Width of the dividend handed to the divider (sum magnitude plus half count).
    localparam int DIVIDEND_W = 30;

    // CORDIC start value: the inverse of the rotation gain in Q30.
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // Number of CORDIC micro-rotations.
    localparam int CORDIC_ITERS = 16;

    // Largest centroid magnitude in millimetres.
    localparam logic [15:0] CENTROID_LIM = 16'hFFFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE = 2'd0,
        REG_ANGLE_STEP  = 2'd1,
        REG_RANGE_FLOOR = 2'd2,
        REG_RANGE_CEIL  = 2'd3
    } t_cfg_reg;

    // Arctangent of 2^-i in units of one quarter turn over 2^30.
    function automatic logic signed [31:0] atan_q30(input logic [3:0] idx);
        logic signed [31:0] val;
        case (idx)
            4'd0:    val = 32'sd536870912;
            4'd1:    val = 32'sd316933406;
            4'd2:    val = 32'sd167458907;
            4'd3:    val = 32'sd85004756;
            4'd4:    val = 32'sd42667331;
            4'd5:    val = 32'sd21354465;
            4'd6:    val = 32'sd10680862;
            4'd7:    val = 32'sd5340245;
            4'd8:    val = 32'sd2670163;
            4'd9:    val = 32'sd1335087;
            4'd10:   val = 32'sd667544;
            4'd11:   val = 32'sd333772;
            4'd12:   val = 32'sd166886;
            4'd13:   val = 32'sd83443;
            4'd14:   val = 32'sd41722;
            4'd15:   val = 32'sd20861;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/lcent_div.sv
module lcent_div #(
    parameter int N_W = lcent_pkg::DIVIDEND_W,
    parameter int D_W = $clog2(lcent_pkg::MAX_SAMPLES_DEF) + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);

    localparam int CW = $clog2(N_W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N_W-1:0] r_quo;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_div;

    logic [D_W:0]   w_shift;
    logic [D_W+1:0] w_diff;
    logic           w_fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb begin
        w_shift = {r_rem, r_quo[N_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_fits  = !w_diff[D_W+1];
    end

    // Control: the step counter runs one dividend bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out of the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hdl/laser_scan_centroid_core.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// in        in         i_in_valid / o_in_stall    i_range_mm, i_last_of_scan
// out       out        o_out_valid / i_out_stall  o_centroid_x_mm, o_centroid_y_mm,
//                                                 o_points_used, o_no_valid_points
//
// A sample outside the range window goes straight to the step state; a counted sample
// also passes through the 16 iterations of the shared CORDIC rotator and the shared multiplier.
// The last sample of a scan with counted points then waits on the serial divider,
// which forms the x and then the y mean; an empty scan goes straight to the emit state.
// Reset is synchronous and active low; configuration is taken in any cycle.
// A stalled result waits in the output register while the next sample is worked.
module laser_scan_centroid_core #(
    parameter int MAX_SAMPLES = lcent_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lcent_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                         i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [15:0]                         i_range_mm,
    input  logic                                i_last_of_scan,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [16:0]                  o_centroid_x_mm,
    output logic signed [16:0]                  o_centroid_y_mm,
    output logic [$clog2(MAX_SAMPLES):0]        o_points_used,
    output logic                                o_no_valid_points
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES) + 1;
    localparam int AB    = lcent_pkg::ANGLE_BITS;
    localparam int SW    = lcent_pkg::SUM_W;
    localparam int NW    = lcent_pkg::DIVIDEND_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_PHASE = 12'b000000000010,
        S_INIT  = 12'b000000000100,
        S_ROT   = 12'b000000001000,
        S_TRIG  = 12'b000000010000,
        S_MULX  = 12'b000000100000,
        S_MULY  = 12'b000001000000,
        S_ADDY  = 12'b000010000000,
        S_STEP  = 12'b000100000000,
        S_DIVX  = 12'b001000000000,
        S_DIVY  = 12'b010000000000,
        S_EMIT  = 12'b100000000000
    } t_state;

    typedef enum logic [1:0] {
        Q_FIRST  = 2'd0,
        Q_SECOND = 2'd1,
        Q_THIRD  = 2'd2,
        Q_FOURTH = 2'd3
    } t_quad;

    // Q30 CORDIC output to Q16, rounded half away from zero, clamped to one.
    function automatic logic signed [17:0] q30_to_q16(input logic signed [32:0] v);
        logic [32:0] mag;
        logic [33:0] rnd;
        logic [17:0] m18;
        mag = v[32] ? 33'(-v) : 33'(v);
        rnd = (34'(mag) + 34'd8192) >> 14;
        m18 = (rnd > 34'd65536) ? 18'd65536 : rnd[17:0];
        return v[32] ? -m18 : m18;
    endfunction

    // Range times Q16 trig back to millimetres, rounded half away from zero.
    function automatic logic signed [16:0] prod_to_mm(input logic signed [35:0] p);
        logic [35:0] mag;
        logic [36:0] rnd;
        logic [16:0] m17;
        mag = p[35] ? 36'(-p) : 36'(p);
        rnd = (37'(mag) + 37'd32768) >> 16;
        m17 = rnd[16:0];
        return p[35] ? -m17 : m17;
    endfunction

    // Running sum plus one term, saturated to the sum width.
    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] s,
                                                     input logic signed [16:0] t);
        logic signed [SW:0] n;
        n = {s[SW-1], s} + {{(SW - 16){t[16]}}, t};
        if (n[SW] != n[SW-1]) begin
            return n[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end
        return n[SW-1:0];
    endfunction

    // Divider quotient to a signed, clamped centroid.
    function automatic logic signed [16:0] to_centroid(input logic [NW-1:0] q,
                                                       input logic neg);
        logic [16:0] m17;
        m17 = (q > NW'(lcent_pkg::CENTROID_LIM)) ? {1'b0, lcent_pkg::CENTROID_LIM}
                                                 : {1'b0, q[15:0]};
        return neg ? -m17 : m17;
    endfunction

    t_state n_state;
    t_state r_state;

    logic [15:0]              r_start_angle;
    logic [15:0]              r_angle_step;
    logic [15:0]              r_range_floor;
    logic [15:0]              r_range_ceil;

    logic [IDX_W-1:0]         r_idx;
    logic [CNT_W-1:0]         r_count;
    logic signed [SW-1:0]     r_sum_x;
    logic signed [SW-1:0]     r_sum_y;
    logic [3:0]               r_iter;
    logic                     r_out_valid;

    logic [15:0]              r_range;
    logic                     r_last;
    logic signed [35:0]       r_prod;
    logic signed [32:0]       r_x;
    logic signed [32:0]       r_y;
    logic signed [31:0]       r_z;
    t_quad                    r_quad;
    logic signed [17:0]       r_cos;
    logic signed [17:0]       r_sin;
    logic signed [16:0]       r_cx;

    logic signed [16:0]       r_out_cx;
    logic signed [16:0]       r_out_cy;
    logic [CNT_W-1:0]         r_out_pts;
    logic                     r_out_none;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic [15:0]              w_range;
    logic                     w_hit;
    logic signed [17:0]       w_mul_a;
    logic signed [17:0]       w_mul_b;
    logic signed [35:0]       w_mul_p;
    logic [31:0]              w_ang_sum;
    logic [AB-1:0]            w_ang;
    logic [31:0]              w_phase;
    logic signed [32:0]       w_dx;
    logic signed [32:0]       w_dy;
    logic signed [17:0]       w_c;
    logic signed [17:0]       w_s;
    logic signed [17:0]       w_cq;
    logic signed [17:0]       w_sq;
    logic                     w_div_start;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic [NW-1:0]            w_div_dividend;
    logic [NW-1:0]            w_div_quo;
    logic signed [SW-1:0]     w_div_sum;
    logic [SW-1:0]            w_div_mag;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_range    = i_range_mm & lcent_pkg::RANGE_MASK;
    assign w_hit      = (r_range_floor < w_range) && (w_range < r_range_ceil);

    // Shared multiplier: angle offset, then range times cosine and sine.
    always_comb begin
        w_mul_a = 18'(r_range);
        w_mul_b = r_cos;
        case (r_state)
            S_PHASE: begin
                w_mul_a = 18'(r_idx);
                w_mul_b = 18'(r_angle_step);
            end
            S_MULY: begin
                w_mul_b = r_sin;
            end
            default: begin
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    // Sample angle wrapped to the angle width, then placed as a 32-bit phase.
    assign w_ang_sum = 32'(r_start_angle) + r_prod[31:0];
    assign w_ang     = w_ang_sum[AB-1:0];
    assign w_phase   = 32'(w_ang) << (32 - AB);

    // One CORDIC micro-rotation per cycle through the shared shifters.
    assign w_dx = r_y >>> r_iter;
    assign w_dy = r_x >>> r_iter;

    // Rounded trig values, mapped back into their quadrant.
    always_comb begin
        w_cq = q30_to_q16(r_x);
        w_sq = q30_to_q16(r_y);
        case (r_quad)
            Q_FIRST: begin
                w_c = w_cq;
                w_s = w_sq;
            end
            Q_SECOND: begin
                w_c = -w_sq;
                w_s = w_cq;
            end
            Q_THIRD: begin
                w_c = -w_cq;
                w_s = -w_sq;
            end
            Q_FOURTH: begin
                w_c = w_sq;
                w_s = -w_cq;
            end
            default: begin
                w_c = w_cq;
                w_s = w_sq;
            end
        endcase
    end

    // Divider request: x mean after the last sample, y mean once x is done.
    assign w_div_start = ((r_state == S_STEP) && r_last && (r_count != '0))
                      || ((r_state == S_DIVX) && w_div_done);
    assign w_div_sum   = (r_state == S_DIVX) ? r_sum_y : r_sum_x;
    assign w_div_mag   = w_div_sum[SW-1] ? SW'(-w_div_sum) : SW'(w_div_sum);
    assign w_div_dividend = NW'(w_div_mag) + NW'(r_count >> 1);

    lcent_div #(
        .N_W(NW),
        .D_W(CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_hit ? S_PHASE : S_STEP;
                end
            end
            S_PHASE: n_state = S_INIT;
            S_INIT:  n_state = S_ROT;
            S_ROT: begin
                if (r_iter == 4'(lcent_pkg::CORDIC_ITERS - 1)) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG:  n_state = S_MULX;
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_ADDY;
            S_ADDY:  n_state = S_STEP;
            S_STEP: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                if (w_div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and scan accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start_angle <= '0;
            r_angle_step  <= '0;
            r_range_floor <= '0;
            r_range_ceil  <= 16'hFFFF;
            r_idx         <= '0;
            r_count       <= '0;
            r_sum_x       <= '0;
            r_sum_y       <= '0;
            r_iter        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lcent_pkg::REG_START_ANGLE: r_start_angle <= i_cfg_data;
                    lcent_pkg::REG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
                    lcent_pkg::REG_RANGE_FLOOR: r_range_floor <= i_cfg_data;
                    lcent_pkg::REG_RANGE_CEIL:  r_range_ceil  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == S_INIT) begin
                r_iter <= '0;
            end else if (r_state == S_ROT) begin
                r_iter <= r_iter + 4'd1;
            end

            if (r_state == S_MULY) begin
                r_sum_x <= sat_add(r_sum_x, prod_to_mm(r_prod));
            end

            if (r_state == S_ADDY) begin
                r_sum_y <= sat_add(r_sum_y, prod_to_mm(r_prod));
                if (r_count < CNT_W'(MAX_SAMPLES)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end

            if (r_state == S_STEP) begin
                if (r_last || (r_idx == IDX_W'(MAX_SAMPLES - 1))) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // The output register drains on its own; a new result loads once free.
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-sample datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_range <= w_range;
            r_last  <= i_last_of_scan;
        end

        if ((r_state == S_PHASE) || (r_state == S_MULX) || (r_state == S_MULY)) begin
            r_prod <= w_mul_p;
        end

        if (r_state == S_INIT) begin
            r_quad <= t_quad'(w_phase[31:30]);
            r_x    <= lcent_pkg::CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= {2'b00, w_phase[29:0]};
        end else if (r_state == S_ROT) begin
            if (!r_z[31]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - lcent_pkg::atan_q30(r_iter);
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + lcent_pkg::atan_q30(r_iter);
            end
        end

        if (r_state == S_TRIG) begin
            r_cos <= w_c;
            r_sin <= w_s;
        end

        if ((r_state == S_DIVX) && w_div_done) begin
            r_cx <= to_centroid(w_div_quo, r_sum_x[SW-1]);
        end

        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_pts  <= r_count;
            r_out_none <= (r_count == '0);
            if (r_count == '0) begin
                r_out_cx <= '0;
                r_out_cy <= '0;
            end else begin
                r_out_cx <= r_cx;
                r_out_cy <= to_centroid(w_div_quo, r_sum_y[SW-1]);
            end
        end
    end

    // The y quotient stays on the divider output until the result is loaded.
    assign o_cfg_ready       = 1'b1;
    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_centroid_x_mm   = r_out_cx;
    assign o_centroid_y_mm   = r_out_cy;
    assign o_points_used     = r_out_pts;
    assign o_no_valid_points = r_out_none;

`ifndef SYNTHESIS
    // The valid count never runs past its saturation limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("valid count beyond its limit");

    // A divide request is only made while the divider is free.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    // Loading a result clears the scan accumulators and raises the output.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && w_out_free) |=>
            (o_out_valid && (r_count == '0) && (r_sum_x == '0) && (r_sum_y == '0)))
        else $error("result load did not clear the scan state");

    // An empty scan reports a zero centroid and no points.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_valid_points) |->
            ((o_centroid_x_mm == '0) && (o_centroid_y_mm == '0) && (o_points_used == '0)))
        else $error("empty scan with a nonzero result");

    // A sample is accepted only when its work cannot collide with a pending divide.
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> !w_div_busy)
        else $error("sample accepted during a divide");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int     RANDOM_SAMPLES = 1200;
    localparam int     LONG_SCAN_LEN  = 300;
    localparam int     DRAIN_CYCLES   = 120;
    localparam int     END_CYCLES     = 150;
    localparam int     STALL_LIMIT    = 4000;
    localparam int     MAX_POINTS     = 4096;
    localparam longint SUM_HI         = 64'sd536870911;
    localparam longint SUM_LO         = -64'sd536870912;
    localparam longint MEAN_LIM       = 64'sd65535;
    localparam longint TRIG_LIM       = 64'sd65536;
    localparam longint ROTATOR_START  = 64'sd652032874;

    // Quadrant of the 32-bit phase, from its top two bits.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    typedef struct packed {
        logic signed [16:0] x_mm;
        logic signed [16:0] y_mm;
        logic [12:0]        used;
        logic               empty_scan;
    } t_centroid;

    typedef struct packed {
        logic [15:0] dist_mm;
        logic        end_of_scan;
        logic        fixed;
        t_centroid   answer;
    } t_sample_row;

    localparam t_centroid NO_POINTS  = '{17'sd0, 17'sd0, 13'd0, 1'b1};
    localparam t_centroid ANY_RESULT = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_range_mm = '0;
    logic               i_last_of_scan = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [16:0] o_centroid_x_mm;
    logic signed [16:0] o_centroid_y_mm;
    logic [12:0]        o_points_used;
    logic               o_no_valid_points;

    // Shadow of the window registers and of the scan accumulators.
    logic [15:0] ang_start = 16'd0;
    logic [15:0] ang_step  = 16'd0;
    logic [15:0] floor_mm  = 16'd0;
    logic [15:0] ceil_mm   = 16'hFFFF;
    logic [11:0] scan_pos  = 12'd0;
    int          hits      = 0;
    longint      sum_x_mm  = 0;
    longint      sum_y_mm  = 0;

    longint arctan_q30 [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    t_centroid   pending_centroids [$];
    t_sample_row directed_rows [16];
    int          mismatches    = 0;
    int          samples_sent  = 0;
    int          in_gap_pct    = 0;
    int          out_stall_pct = 0;
    int          idle_cycles   = 0;

    laser_scan_centroid_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_range_mm        (i_range_mm),
        .i_last_of_scan    (i_last_of_scan),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_centroid_x_mm   (o_centroid_x_mm),
        .o_centroid_y_mm   (o_centroid_y_mm),
        .o_points_used     (o_points_used),
        .o_no_valid_points (o_no_valid_points)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Right shift that rounds half away from zero.
    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    // Q16 cosine and sine of a phase where one turn is 2^32.
    function automatic void unit_vector(input logic [31:0] phase, output longint c,
                                        output longint s);
        longint vx, vy, vz, dx, dy;
        vx = ROTATOR_START;
        vy = 0;
        vz = longint'(phase[29:0]);
        for (int i = 0; i < 16; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vz >= 0) begin
                vx -= dx;
                vy += dy;
                vz -= arctan_q30[i];
            end else begin
                vx += dx;
                vy -= dy;
                vz += arctan_q30[i];
            end
        end
        vx = clip(round_away(vx, 14), -TRIG_LIM, TRIG_LIM);
        vy = clip(round_away(vy, 14), -TRIG_LIM, TRIG_LIM);
        case (phase[31:30])
            QUAD_FIRST: begin
                c = vx;
                s = vy;
            end
            QUAD_SECOND: begin
                c = -vy;
                s = vx;
            end
            QUAD_THIRD: begin
                c = -vx;
                s = -vy;
            end
            default: begin
                c = vy;
                s = -vx;
            end
        endcase
    endfunction

    // Mean of a coordinate sum, rounded half away from zero and limited.
    function automatic longint mean_mm(input longint total, input int n);
        longint d, q;
        d = n;
        if (total >= 0) begin
            q = (total + d / 2) / d;
        end else begin
            q = -((-total + d / 2) / d);
        end
        return clip(q, -MEAN_LIM, MEAN_LIM);
    endfunction

    // Fold one sample into the scan; returns 1 with the centroid on the last sample.
    function automatic bit scan_absorb(input logic [15:0] sample_mm, input logic last,
                                       output t_centroid res);
        logic [31:0] turns;
        logic [15:0] ang;
        longint      c, s;
        res = '0;
        if (floor_mm < sample_mm && sample_mm < ceil_mm) begin
            turns = 32'(scan_pos) * 32'(ang_step);
            ang = ang_start + turns[15:0];
            unit_vector({ang, 16'h0000}, c, s);
            sum_x_mm = clip(sum_x_mm + round_away(longint'(sample_mm) * c, 16),
                            SUM_LO, SUM_HI);
            sum_y_mm = clip(sum_y_mm + round_away(longint'(sample_mm) * s, 16),
                            SUM_LO, SUM_HI);
            if (hits < MAX_POINTS) begin
                hits++;
            end
        end
        scan_pos = scan_pos + 12'd1;
        if (!last) begin
            return 1'b0;
        end
        if (hits == 0) begin
            res = NO_POINTS;
        end else begin
            res.x_mm = 17'(mean_mm(sum_x_mm, hits));
            res.y_mm = 17'(mean_mm(sum_y_mm, hits));
            res.used = 13'(hits);
            res.empty_scan = 1'b0;
        end
        scan_pos = 12'd0;
        hits = 0;
        sum_x_mm = 0;
        sum_y_mm = 0;
        return 1'b1;
    endfunction

    // Range sample aimed mostly inside the current window, sometimes at its edges.
    function automatic logic [15:0] pick_dist();
        int lo, hi, sel;
        lo = floor_mm;
        hi = ceil_mm;
        sel = $urandom_range(0, 99);
        if (hi > lo + 1 && sel < 70) begin
            return 16'($urandom_range(lo + 1, hi - 1));
        end
        if (sel < 80) begin
            return (sel % 2 == 0) ? floor_mm : ceil_mm;
        end
        if (sel < 86) begin
            return (sel % 2 == 0) ? 16'h0000 : 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Drive one sample request, wait until it is taken, then record its centroid.
    task automatic push_sample(input logic [15:0] sample_mm, input logic last,
                               input logic use_fixed, input t_centroid fixed_ans);
        t_centroid predicted;
        bit        produces;
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_range_mm <= sample_mm;
        i_last_of_scan <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        produces = scan_absorb(sample_mm, last, predicted);
        if (produces) begin
            pending_centroids.push_back(use_fixed ? fixed_ans : predicted);
        end
    endtask

    task automatic cfg_write(input lcent_pkg::t_cfg_reg idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            lcent_pkg::REG_START_ANGLE: ang_start = val;
            lcent_pkg::REG_ANGLE_STEP:  ang_step = val;
            lcent_pkg::REG_RANGE_FLOOR: floor_mm = val;
            default:                    ceil_mm = val;
        endcase
    endtask

    task automatic program_window(input logic [15:0] start, input logic [15:0] step,
                                  input logic [15:0] lo, input logic [15:0] hi);
        cfg_write(lcent_pkg::REG_START_ANGLE, start);
        cfg_write(lcent_pkg::REG_ANGLE_STEP, step);
        cfg_write(lcent_pkg::REG_RANGE_FLOOR, lo);
        cfg_write(lcent_pkg::REG_RANGE_CEIL, hi);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off new samples until every centroid is out and the block has settled.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_centroids.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_scan();
        int sel, len;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            len = $urandom_range(1, 12);
        end else if (sel < 96) begin
            len = $urandom_range(13, 60);
        end else begin
            len = $urandom_range(61, 250);
        end
        for (int k = 0; k < len; k++) begin
            push_sample(pick_dist(), k == len - 1, 1'b0, ANY_RESULT);
        end
        samples_sent += len;
    endtask

    task automatic check_field(input string label, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Compare each accepted centroid with the oldest one pending.
    always @(posedge i_clk) begin
        t_centroid got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_centroid_x_mm, o_centroid_y_mm, o_points_used, o_no_valid_points};
            if (pending_centroids.size() == 0) begin
                mismatches++;
                $display("%0t: centroid expected none, got x=%0d y=%0d used=%0d empty=%0b",
                         $time, got.x_mm, got.y_mm, got.used, got.empty_scan);
            end else begin
                want = pending_centroids.pop_front();
                check_field("centroid_x_mm", longint'(want.x_mm), longint'(got.x_mm));
                check_field("centroid_y_mm", longint'(want.y_mm), longint'(got.y_mm));
                check_field("points_used", longint'(want.used), longint'(got.used));
                check_field("no_valid_points", longint'(want.empty_scan),
                            longint'(got.empty_scan));
            end
        end
    end

    // Watchdog on cycles with no request taken on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int seg;
        int n_scans;

        // Directed samples under the reset window: every angle is zero.
        directed_rows = '{
            '{16'd0,     1'b1, 1'b1, NO_POINTS},
            '{16'hFFFF,  1'b1, 1'b1, NO_POINTS},
            '{16'd1000,  1'b1, 1'b1, '{17'sd1000, 17'sd0, 13'd1, 1'b0}},
            '{16'd0,     1'b0, 1'b0, ANY_RESULT},
            '{16'hFFFF,  1'b0, 1'b0, ANY_RESULT},
            '{16'd0,     1'b1, 1'b1, NO_POINTS},
            '{16'd1,     1'b0, 1'b0, ANY_RESULT},
            '{16'hFFFE,  1'b0, 1'b0, ANY_RESULT},
            '{16'hFFFF,  1'b1, 1'b0, ANY_RESULT},
            '{16'd200,   1'b0, 1'b0, ANY_RESULT},
            '{16'd400,   1'b1, 1'b1, '{17'sd300, 17'sd0, 13'd2, 1'b0}},
            '{16'hFFFE,  1'b0, 1'b0, ANY_RESULT},
            '{16'hFFFE,  1'b0, 1'b0, ANY_RESULT},
            '{16'hFFFE,  1'b1, 1'b0, ANY_RESULT},
            '{16'hAAAA,  1'b0, 1'b0, ANY_RESULT},
            '{16'h5555,  1'b1, 1'b0, ANY_RESULT}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_gap_pct = 24;
        out_stall_pct = 75;
        foreach (directed_rows[n]) begin
            push_sample(directed_rows[n].dist_mm, directed_rows[n].end_of_scan,
                        directed_rows[n].fixed, directed_rows[n].answer);
        end

        // Random scans, with a fresh window each segment and three idling regimes.
        seg = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            drain_block();
            if (samples_sent < RANDOM_SAMPLES / 3) begin
                in_gap_pct = 24;
                out_stall_pct = 75;
            end else if (samples_sent < 2 * RANDOM_SAMPLES / 3) begin
                in_gap_pct = 75;
                out_stall_pct = 24;
            end else begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end
            case (seg % 6)
                0: program_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: program_window(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
                2: program_window(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
                3: program_window(16'($urandom), 16'($urandom),
                                  16'($urandom_range(0, 30000)),
                                  16'($urandom_range(35000, 65535)));
                4: program_window(16'($urandom), 16'($urandom_range(0, 15)),
                                  16'h0000, 16'hFFFF);
                default: program_window(16'h8000, 16'h4000,
                                        16'($urandom_range(0, 1000)), 16'hFFFF);
            endcase
            n_scans = $urandom_range(3, 10);
            repeat (n_scans) send_scan();
            seg++;
        end

        // One long scan of near full range samples at small angles, sent back to back.
        drain_block();
        in_gap_pct = 0;
        out_stall_pct = 0;
        program_window(16'h0000, 16'h0001, 16'h0000, 16'hFFFF);
        for (int k = 0; k < LONG_SCAN_LEN; k++) begin
            push_sample(16'($urandom_range(65000, 65534)), k == LONG_SCAN_LEN - 1,
                        1'b0, ANY_RESULT);
        end

        i_in_valid <= 1'b0;
        while (pending_centroids.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
